// File: hdl/disc_pair_collision_resolve_core_defines.svh
// Assertion macros used by the checker of this block.
`ifndef DISC_PAIR_COLLISION_RESOLVE_CORE_DEFINES_SVH
`define DISC_PAIR_COLLISION_RESOLVE_CORE_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define DPCR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define DPCR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also watches the reset itself.
`define DPCR_ASSERT_ALWAYS_NEXT(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/dpcr_pkg.sv
package dpcr_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int W_BITS        = 24;
    localparam int E_BITS        = 17;
    localparam int E_FRAC        = 16;
    localparam logic [E_BITS-1:0] E_ONE = 17'd65536;
    localparam int QUEUE_DEPTH   = 4;
    localparam int IN_TDATA_W    = 384;
    localparam int OUT_TDATA_W   = 256;
    localparam int OUT_TUSER_W   = 2;

    typedef struct packed {
        logic signed [31:0] p1x;
        logic signed [31:0] p1y;
        logic signed [31:0] v1x;
        logic signed [31:0] v1y;
        logic signed [31:0] p2x;
        logic signed [31:0] p2y;
        logic signed [31:0] v2x;
        logic signed [31:0] v2y;
    } t_disc_state;

    typedef struct packed {
        t_disc_state st;
        logic        sgn_x;
        logic        sgn_y;
        logic        cand;
        logic [31:0] ax;
        logic [31:0] ay;
        logic [31:0] rs;
        logic [31:0] m1;
        logic [31:0] m2;
        logic [32:0] msum;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        t_disc_state st;
        logic        in_contact;
        logic        impulse;
    } t_out;

    typedef struct packed {
        logic [63:0] rem;
        logic [31:0] root;
    } t_sq_res;

    typedef struct packed {
        logic [33:0] rem;
        logic        q;
    } t_div_res;

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        if (v > 40'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -40'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // base +/- mag, saturated
    function automatic logic signed [31:0] adj(input logic [31:0] base,
                                               input logic [34:0] mag,
                                               input logic sub);
        logic [39:0] wide;
        logic [39:0] m;
        logic [39:0] res;
        wide = {{8{base[31]}}, base};
        m    = {5'b0, mag};
        res  = sub ? (wide - m) : (wide + m);
        return sat32(res);
    endfunction

    // one root bit: rem holds v - root^2, root has bits above b only
    function automatic t_sq_res sqrt_step(input logic [63:0] rem,
                                          input logic [31:0] root,
                                          input int b);
        t_sq_res     res;
        logic [64:0] trial;
        trial = ({33'b0, root} << (b + 1)) + (65'd1 << (2 * b));
        res.rem  = rem;
        res.root = root;
        if ({1'b0, rem} >= trial) begin
            res.rem  = rem - trial[63:0];
            res.root = root | (32'd1 << b);
        end
        return res;
    endfunction

    // one restoring division bit
    function automatic t_div_res div_step(input logic [33:0] rem,
                                          input logic [32:0] den,
                                          input logic dbl);
        t_div_res    res;
        logic [34:0] r2;
        r2 = dbl ? {rem, 1'b0} : {1'b0, rem};
        if (r2 >= {2'b0, den}) begin
            r2    = r2 - {2'b0, den};
            res.q = 1'b1;
        end else begin
            res.q = 1'b0;
        end
        res.rem = r2[33:0];
        return res;
    endfunction

endpackage

// File: hdl/dpcr_front.sv
module dpcr_front import dpcr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [IN_TDATA_W-1:0] i_data,
    input  t_q_stat               i_q_stat,
    output logic                  o_push,
    output t_item                 o_item
);

    logic        r_valid;
    logic        n_valid;
    t_item       r_item;
    t_item       w_item;
    logic [32:0] w_dx;
    logic [32:0] w_dy;
    logic [31:0] w_r1;
    logic [31:0] w_r2;

    always_comb begin
        w_item.st.p1x = i_data[31:0];
        w_item.st.p1y = i_data[63:32];
        w_item.st.v1x = i_data[95:64];
        w_item.st.v1y = i_data[127:96];
        w_item.st.p2x = i_data[222:191];
        w_item.st.p2y = i_data[254:223];
        w_item.st.v2x = i_data[286:255];
        w_item.st.v2y = i_data[318:287];
        w_r1 = {1'b0, i_data[190:160]};
        w_r2 = {1'b0, i_data[381:351]};
        w_dx = {i_data[222], i_data[222:191]} - {i_data[31], i_data[31:0]};
        w_dy = {i_data[254], i_data[254:223]} - {i_data[63], i_data[63:32]};
        w_item.sgn_x = w_dx[32];
        w_item.sgn_y = w_dy[32];
        w_item.ax = w_dx[32] ? 32'(-w_dx) : w_dx[31:0];
        w_item.ay = w_dy[32] ? 32'(-w_dy) : w_dy[31:0];
        w_item.rs = w_r1 + w_r2;
        w_item.cand = (w_item.ax < w_item.rs) && (w_item.ay < w_item.rs);
        // treat a zero mass as one LSB
        w_item.m1 = (i_data[159:128] == 32'd0) ? 32'd1 : i_data[159:128];
        w_item.m2 = (i_data[350:319] == 32'd0) ? 32'd1 : i_data[350:319];
        w_item.msum = {1'b0, w_item.m1} + {1'b0, w_item.m2};
    end

    assign o_push  = r_valid && !i_q_stat.full;
    assign o_ready = !r_valid || !i_q_stat.full;
    assign o_item  = r_item;

    always_comb begin
        n_valid = r_valid;
        if (i_valid && o_ready) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= w_item;
        end
    end

endmodule

// File: hdl/dpcr_queue.sv
module dpcr_queue import dpcr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_item   i_item,
    input  logic    i_pop,
    output t_q_stat o_stat,
    output t_item   o_item
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_item         r_mem [0:QUEUE_DEPTH-1];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic [AW-1:0] n_wr_ptr;
    logic [AW-1:0] n_rd_ptr;
    logic [CW-1:0] n_count;

    assign o_stat.full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_item       = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// File: hdl/dpcr_back.sv
module dpcr_back import dpcr_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_item             i_item,
    input  t_q_stat           i_q_stat,
    output logic              o_pop,
    input  logic [E_BITS-1:0] i_restitution,
    input  logic              i_ready,
    output logic              o_valid,
    output t_out              o_res
);

    localparam int NW       = FRAC_BITS + 1;
    localparam int SQ_STEPS = 32;
    localparam int F        = FRAC_BITS;

    typedef struct packed {
        t_item               it;
        logic                ok;
        logic [63:0]         rem;
        logic [31:0]         root;
        logic [33:0]         wr1;
        logic [33:0]         wr2;
        logic [W_BITS-1:0]   wq1;
        logic [W_BITS-1:0]   wq2;
    } t_sqs;

    typedef struct packed {
        t_disc_state         st;
        logic                sgn_x;
        logic                sgn_y;
        logic                ok;
        logic [31:0]         span;
        logic [31:0]         pen;
        logic [W_BITS-1:0]   w1;
        logic [W_BITS-1:0]   w2;
        logic [33:0]         rx;
        logic [33:0]         ry;
        logic [F:0]          qx;
        logic [F:0]          qy;
    } t_dvs;

    typedef struct packed {
        t_disc_state         st;
        logic                sgn_x;
        logic                sgn_y;
        logic                ok;
        logic [F:0]          nmx;
        logic [F:0]          nmy;
        logic [W_BITS-1:0]   w1;
        logic [W_BITS-1:0]   w2;
    } t_pc;

    logic w_en;

    // stage valids
    logic r_b0_v;
    logic r_sq_v [0:SQ_STEPS];
    logic r_dv_v [0:NW];
    logic r_p_v  [0:5];
    logic r_out_v;

    // whole pipe advances unless the result is held
    assign w_en    = !r_out_v || i_ready;
    assign o_pop   = w_en && !i_q_stat.empty;
    assign o_valid = r_out_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0_v <= 1'b0;
        end else if (w_en) begin
            r_b0_v <= o_pop;
        end
    end

    // squares
    t_item       r_b0_it;
    logic [63:0] r_b0_sx;
    logic [63:0] r_b0_sy;
    logic [63:0] r_b0_rr;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b0_it <= i_item;
            r_b0_sx <= i_item.ax * i_item.ax;
            r_b0_sy <= i_item.ay * i_item.ay;
            r_b0_rr <= i_item.rs * i_item.rs;
        end
    end

    // overlap test
    logic [64:0] w_s;
    logic        w_ok;
    t_sqs        r_sq [0:SQ_STEPS];

    assign w_s  = {1'b0, r_b0_sx} + {1'b0, r_b0_sy};
    assign w_ok = r_b0_it.cand && !w_s[64] && (w_s[63:0] < r_b0_rr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v[0] <= 1'b0;
        end else if (w_en) begin
            r_sq_v[0] <= r_b0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq[0].it   <= r_b0_it;
            r_sq[0].ok   <= w_ok;
            r_sq[0].rem  <= w_s[63:0];
            r_sq[0].root <= '0;
            r_sq[0].wr1  <= {2'b0, r_b0_it.m2};
            r_sq[0].wr2  <= {2'b0, r_b0_it.m1};
            r_sq[0].wq1  <= '0;
            r_sq[0].wq2  <= '0;
        end
    end

    // root bit per stage; mass weights share the first stages
    for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqrt
        t_sq_res  w_sr;
        t_div_res w_d1;
        t_div_res w_d2;

        always_comb begin
            w_sr = sqrt_step(r_sq[g].rem, r_sq[g].root, SQ_STEPS - 1 - g);
            w_d1 = div_step(r_sq[g].wr1, r_sq[g].it.msum, 1'b1);
            w_d2 = div_step(r_sq[g].wr2, r_sq[g].it.msum, 1'b1);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[g+1] <= 1'b0;
            end else if (w_en) begin
                r_sq_v[g+1] <= r_sq_v[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sq[g+1]      <= r_sq[g];
                r_sq[g+1].rem  <= w_sr.rem;
                r_sq[g+1].root <= w_sr.root;
                if (g < W_BITS) begin
                    r_sq[g+1].wr1 <= w_d1.rem;
                    r_sq[g+1].wr2 <= w_d2.rem;
                    r_sq[g+1].wq1 <= {r_sq[g].wq1[W_BITS-2:0], w_d1.q};
                    r_sq[g+1].wq2 <= {r_sq[g].wq2[W_BITS-2:0], w_d2.q};
                end
            end
        end
    end

    // normal division setup
    t_dvs r_dv [0:NW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else if (w_en) begin
            r_dv_v[0] <= r_sq_v[SQ_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dv[0].st    <= r_sq[SQ_STEPS].it.st;
            r_dv[0].sgn_x <= r_sq[SQ_STEPS].it.sgn_x;
            r_dv[0].sgn_y <= r_sq[SQ_STEPS].it.sgn_y;
            // drop coincident pairs
            r_dv[0].ok    <= r_sq[SQ_STEPS].ok && (r_sq[SQ_STEPS].root != 32'd0);
            r_dv[0].span  <= r_sq[SQ_STEPS].root;
            r_dv[0].pen   <= r_sq[SQ_STEPS].it.rs - r_sq[SQ_STEPS].root;
            r_dv[0].w1    <= r_sq[SQ_STEPS].wq1;
            r_dv[0].w2    <= r_sq[SQ_STEPS].wq2;
            r_dv[0].rx    <= {2'b0, r_sq[SQ_STEPS].it.ax};
            r_dv[0].ry    <= {2'b0, r_sq[SQ_STEPS].it.ay};
            r_dv[0].qx    <= '0;
            r_dv[0].qy    <= '0;
        end
    end

    // first step takes the integer bit, no doubling
    for (genvar j = 0; j < NW; j++) begin : g_ndiv
        t_div_res w_x;
        t_div_res w_y;

        always_comb begin
            w_x = div_step(r_dv[j].rx, {1'b0, r_dv[j].span}, (j != 0));
            w_y = div_step(r_dv[j].ry, {1'b0, r_dv[j].span}, (j != 0));
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[j+1] <= 1'b0;
            end else if (w_en) begin
                r_dv_v[j+1] <= r_dv_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dv[j+1]    <= r_dv[j];
                r_dv[j+1].rx <= w_x.rem;
                r_dv[j+1].ry <= w_y.rem;
                r_dv[j+1].qx <= {r_dv[j].qx[F-1:0], w_x.q};
                r_dv[j+1].qy <= {r_dv[j].qy[F-1:0], w_y.q};
            end
        end
    end

    // post stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_p_v[i] <= 1'b0;
            end
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_p_v[0] <= r_dv_v[NW];
            for (int i = 1; i < 6; i++) begin
                r_p_v[i] <= r_p_v[i-1];
            end
            r_out_v <= r_p_v[5];
        end
    end

    // P0: push shares and closing speed terms
    logic signed [F+1:0]        w_nx_mag;
    logic signed [F+1:0]        w_ny_mag;
    logic signed [F+1:0]        w_nx;
    logic signed [F+1:0]        w_ny;
    logic signed [32:0]         w_dvx;
    logic signed [32:0]         w_dvy;
    t_pc                        r_p0_c;
    logic [W_BITS+31:0]         r_p0_pc1;
    logic [W_BITS+31:0]         r_p0_pc2;
    logic signed [F+34:0]       r_p0_sxp;
    logic signed [F+34:0]       r_p0_syp;

    always_comb begin
        w_nx_mag = {1'b0, r_dv[NW].qx};
        w_ny_mag = {1'b0, r_dv[NW].qy};
        w_nx  = r_dv[NW].sgn_x ? -w_nx_mag : w_nx_mag;
        w_ny  = r_dv[NW].sgn_y ? -w_ny_mag : w_ny_mag;
        w_dvx = {r_dv[NW].st.v2x[31], r_dv[NW].st.v2x}
              - {r_dv[NW].st.v1x[31], r_dv[NW].st.v1x};
        w_dvy = {r_dv[NW].st.v2y[31], r_dv[NW].st.v2y}
              - {r_dv[NW].st.v1y[31], r_dv[NW].st.v1y};
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p0_c.st    <= r_dv[NW].st;
            r_p0_c.sgn_x <= r_dv[NW].sgn_x;
            r_p0_c.sgn_y <= r_dv[NW].sgn_y;
            r_p0_c.ok    <= r_dv[NW].ok;
            r_p0_c.nmx   <= r_dv[NW].qx;
            r_p0_c.nmy   <= r_dv[NW].qy;
            r_p0_c.w1    <= r_dv[NW].w1;
            r_p0_c.w2    <= r_dv[NW].w2;
            r_p0_pc1     <= r_dv[NW].pen * r_dv[NW].w1;
            r_p0_pc2     <= r_dv[NW].pen * r_dv[NW].w2;
            r_p0_sxp     <= w_dvx * w_nx;
            r_p0_syp     <= w_dvy * w_ny;
        end
    end

    // P1: position corrections, closing speed sum
    logic [31:0]    w_c1;
    logic [31:0]    w_c2;
    t_pc            r_p1_c;
    logic [F+32:0]  r_p1_k1x;
    logic [F+32:0]  r_p1_k1y;
    logic [F+32:0]  r_p1_k2x;
    logic [F+32:0]  r_p1_k2y;
    logic [F+35:0]  r_p1_s;

    assign w_c1 = r_p0_pc1[W_BITS+31:W_BITS];
    assign w_c2 = r_p0_pc2[W_BITS+31:W_BITS];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1_c   <= r_p0_c;
            r_p1_k1x <= r_p0_c.nmx * w_c1;
            r_p1_k1y <= r_p0_c.nmy * w_c1;
            r_p1_k2x <= r_p0_c.nmx * w_c2;
            r_p1_k2y <= r_p0_c.nmy * w_c2;
            r_p1_s   <= {r_p0_sxp[F+34], r_p0_sxp} + {r_p0_syp[F+34], r_p0_syp};
        end
    end

    // P2: apply positions, take closing speed magnitude
    logic [F+35:0]  w_abs;
    t_pc            r_p2_c;
    logic [33:0]    r_p2_vm;
    logic           r_p2_neg;

    assign w_abs = r_p1_s[F+35] ? (~r_p1_s + 1'b1) : r_p1_s;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p2_c   <= r_p1_c;
            r_p2_vm  <= w_abs[F+33:F];
            r_p2_neg <= r_p1_s[F+35];
            if (r_p1_c.ok) begin
                r_p2_c.st.p1x <= adj(r_p1_c.st.p1x, {3'b0, r_p1_k1x[F+31:F]}, !r_p1_c.sgn_x);
                r_p2_c.st.p1y <= adj(r_p1_c.st.p1y, {3'b0, r_p1_k1y[F+31:F]}, !r_p1_c.sgn_y);
                r_p2_c.st.p2x <= adj(r_p1_c.st.p2x, {3'b0, r_p1_k2x[F+31:F]}, r_p1_c.sgn_x);
                r_p2_c.st.p2y <= adj(r_p1_c.st.p2y, {3'b0, r_p1_k2y[F+31:F]}, r_p1_c.sgn_y);
            end
        end
    end

    // P3: restitution scaling
    logic [E_BITS-1:0] w_e;
    logic [E_BITS:0]   w_e2;
    t_pc               r_p3_c;
    logic              r_p3_neg;
    logic [51:0]       r_p3_kp;

    assign w_e  = (i_restitution > E_ONE) ? E_ONE : i_restitution;
    assign w_e2 = {1'b0, w_e} + {1'b0, E_ONE};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p3_c   <= r_p2_c;
            r_p3_neg <= r_p2_neg;
            r_p3_kp  <= r_p2_vm * w_e2;
        end
    end

    // P4: impulse shares
    logic [34:0]        w_k;
    t_pc                r_p4_c;
    logic               r_p4_neg;
    logic [W_BITS+34:0] r_p4_d1p;
    logic [W_BITS+34:0] r_p4_d2p;

    assign w_k = r_p3_kp[E_FRAC+34:E_FRAC];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p4_c   <= r_p3_c;
            r_p4_neg <= r_p3_neg;
            r_p4_d1p <= w_k * r_p3_c.w1;
            r_p4_d2p <= w_k * r_p3_c.w2;
        end
    end

    // P5: velocity changes along the normal
    logic [34:0]    w_d1;
    logic [34:0]    w_d2;
    t_pc            r_p5_c;
    logic           r_p5_neg;
    logic [F+35:0]  r_p5_u1x;
    logic [F+35:0]  r_p5_u1y;
    logic [F+35:0]  r_p5_u2x;
    logic [F+35:0]  r_p5_u2y;

    assign w_d1 = r_p4_d1p[W_BITS+34:W_BITS];
    assign w_d2 = r_p4_d2p[W_BITS+34:W_BITS];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p5_c   <= r_p4_c;
            r_p5_neg <= r_p4_neg;
            r_p5_u1x <= r_p4_c.nmx * w_d1;
            r_p5_u1y <= r_p4_c.nmy * w_d1;
            r_p5_u2x <= r_p4_c.nmx * w_d2;
            r_p5_u2y <= r_p4_c.nmy * w_d2;
        end
    end

    // output register
    t_out r_out;
    logic w_imp;

    assign w_imp = r_p5_c.ok && r_p5_neg;
    assign o_res = r_out;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.st         <= r_p5_c.st;
            r_out.in_contact <= r_p5_c.ok;
            r_out.impulse    <= w_imp;
            if (w_imp) begin
                r_out.st.v1x <= adj(r_p5_c.st.v1x, r_p5_u1x[F+34:F], !r_p5_c.sgn_x);
                r_out.st.v1y <= adj(r_p5_c.st.v1y, r_p5_u1y[F+34:F], !r_p5_c.sgn_y);
                r_out.st.v2x <= adj(r_p5_c.st.v2x, r_p5_u2x[F+34:F], r_p5_c.sgn_x);
                r_out.st.v2y <= adj(r_p5_c.st.v2y, r_p5_u2y[F+34:F], r_p5_c.sgn_y);
            end
        end
    end

endmodule

// File: hdl/disc_pair_collision_resolve_core.sv
// The back pipeline holds the 32-stage root pipeline and the FRAC_BITS+1 stage normal divider.
// Throughput: one request per cycle; a stalled result holds the back pipeline,
// while the front keeps accepting until its four-entry queue fills.
// Reset: synchronous, active low; clears all valids and sets restitution to 1.0.
module disc_pair_collision_resolve_core import dpcr_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // first_pos_x, first_pos_y, first_vel_x, first_vel_y, first_mass, first_radius,
    // second_pos_x, second_pos_y, second_vel_x, second_vel_y, second_mass,
    // second_radius, two zero bits
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // new_first_pos_x, new_first_pos_y, new_first_vel_x, new_first_vel_y,
    // new_second_pos_x, new_second_pos_y, new_second_vel_x, new_second_vel_y
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    // in_contact, impulse_applied
    output logic [OUT_TUSER_W-1:0] o_m_axis_tuser,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [E_BITS-1:0]      i_cfg_data
);

    logic [E_BITS-1:0] r_restitution;
    logic              w_push;
    logic              w_pop;
    t_item             w_front_item;
    t_item             w_queue_item;
    t_q_stat           w_q_stat;
    t_out              w_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_restitution <= E_ONE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_restitution <= i_cfg_data;
        end
    end

    dpcr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_data   (i_s_axis_tdata),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_item   (w_front_item)
    );

    dpcr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .i_pop   (w_pop),
        .o_stat  (w_q_stat),
        .o_item  (w_queue_item)
    );

    dpcr_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (w_queue_item),
        .i_q_stat      (w_q_stat),
        .o_pop         (w_pop),
        .i_restitution (r_restitution),
        .i_ready       (i_m_axis_tready),
        .o_valid       (o_m_axis_tvalid),
        .o_res         (w_res)
    );

    assign o_m_axis_tdata = {w_res.st.v2y, w_res.st.v2x, w_res.st.p2y, w_res.st.p2x,
                             w_res.st.v1y, w_res.st.v1x, w_res.st.p1y, w_res.st.p1x};
    assign o_m_axis_tuser = {w_res.impulse, w_res.in_contact};

endmodule

// File: hdl/dpcr_checker.sv
`include "disc_pair_collision_resolve_core_defines.svh"

module dpcr_checker import dpcr_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_m_axis_tvalid,
    input logic                   i_m_axis_tready,
    input logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    input logic [OUT_TUSER_W-1:0] o_m_axis_tuser
);

    // an impulse is only ever applied to a pair in contact
    `DPCR_ASSERT_NOW(a_impulse_needs_contact, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser[1], o_m_axis_tuser[0], "impulse flagged without contact")

    // hold a stalled result
    `DPCR_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser), "stalled result changed")

    // no result straight out of reset
    `DPCR_ASSERT_ALWAYS_NEXT(a_reset_empty, i_clk, !i_rst_n, !o_m_axis_tvalid, "result valid after reset")

endmodule

bind disc_pair_collision_resolve_core dpcr_checker u_checker (.*);

// File: tb/sv/disc_pair_collision_resolve_core_tb.sv
`timescale 1ns / 1ps

module disc_pair_collision_resolve_core_tb;
    import dpcr_pkg::*;

    localparam int FB = FRAC_BITS_DEF;
    localparam int DRAIN_CYCLES = 45 + FB + 20;

    typedef struct {
        logic signed [31:0] p1x, p1y, v1x, v1y;
        logic [31:0]        m1;
        logic [30:0]        r1;
        logic signed [31:0] p2x, p2y, v2x, v2y;
        logic [31:0]        m2;
        logic [30:0]        r2;
    } t_disc_pair;

    typedef struct {
        logic [31:0] p1x, p1y, v1x, v1y, p2x, p2y, v2x, v2y;
        logic        contact;
        logic        impulse;
    } t_resolved;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic [OUT_TUSER_W-1:0] o_m_axis_tuser;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [E_BITS-1:0]      i_cfg_data = '0;

    t_resolved          pending_results[$];
    logic [E_BITS-1:0]  restitution_reg = E_ONE;
    int                 error_count = 0;
    bit                 no_idle = 1'b0;

    disc_pair_collision_resolve_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [63:0] magnitude(longint a);
        return a < 0 ? 64'(-a) : 64'(a);
    endfunction

    // scale a signed value by an unsigned one, truncating the magnitude
    function automatic longint scale_shift(longint a, logic [63:0] b, int sh);
        logic [63:0] m;
        m = (magnitude(a) * b) >> sh;
        return a < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic logic [31:0] clip32(longint v);
        if (v > 64'sd2147483647) return 32'h7fffffff;
        if (v < -64'sd2147483648) return 32'h80000000;
        return v[31:0];
    endfunction

    function automatic logic [63:0] floor_sqrt(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] c;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (c * c <= v) r = c;
        end
        return r;
    endfunction

    function automatic t_resolved resolve_pair(t_disc_pair p, logic [E_BITS-1:0] e_reg);
        t_resolved   res;
        longint      p1x, p1y, v1x, v1y, p2x, p2y, v2x, v2y, dx, dy, nx, ny, s_dot;
        logic [63:0] m1, m2, rs, ax, ay, sx, s, span, msum, w1, w2, pen, c1, c2;
        logic [63:0] e, vm, k, d1, d2;
        p1x = p.p1x; p1y = p.p1y; v1x = p.v1x; v1y = p.v1y;
        p2x = p.p2x; p2y = p.p2y; v2x = p.v2x; v2y = p.v2y;
        m1 = p.m1; m2 = p.m2;
        rs = 64'(p.r1) + 64'(p.r2);
        res.contact = 1'b0;
        res.impulse = 1'b0;
        dx = p2x - p1x;
        dy = p2y - p1y;
        ax = magnitude(dx);
        ay = magnitude(dy);
        if (ax < rs && ay < rs) begin
            sx = ax * ax;
            s = sx + ay * ay;
            span = floor_sqrt(s);
            if (s >= sx && s < rs * rs && span != 0) begin
                nx = longint'((ax << FB) / span);
                ny = longint'((ay << FB) / span);
                if (dx < 0) nx = -nx;
                if (dy < 0) ny = -ny;
                if (m1 == 0) m1 = 1;
                if (m2 == 0) m2 = 1;
                msum = m1 + m2;
                w1 = (m2 << W_BITS) / msum;
                w2 = (m1 << W_BITS) / msum;
                pen = rs - span;
                c1 = (pen * w1) >> W_BITS;
                c2 = (pen * w2) >> W_BITS;
                p1x -= scale_shift(nx, c1, FB);
                p1y -= scale_shift(ny, c1, FB);
                p2x += scale_shift(nx, c2, FB);
                p2y += scale_shift(ny, c2, FB);
                res.contact = 1'b1;
                s_dot = (v2x - v1x) * nx + (v2y - v1y) * ny;
                if (s_dot < 0) begin
                    vm = magnitude(s_dot) >> FB;
                    e = (e_reg > E_ONE) ? 64'(E_ONE) : 64'(e_reg);
                    k = (vm * (64'(E_ONE) + e)) >> E_FRAC;
                    d1 = (k * w1) >> W_BITS;
                    d2 = (k * w2) >> W_BITS;
                    v1x -= scale_shift(nx, d1, FB);
                    v1y -= scale_shift(ny, d1, FB);
                    v2x += scale_shift(nx, d2, FB);
                    v2y += scale_shift(ny, d2, FB);
                    res.impulse = 1'b1;
                end
            end
        end
        res.p1x = clip32(p1x); res.p1y = clip32(p1y);
        res.v1x = clip32(v1x); res.v1y = clip32(v1y);
        res.p2x = clip32(p2x); res.p2y = clip32(p2y);
        res.v2x = clip32(v2x); res.v2y = clip32(v2y);
        return res;
    endfunction

    task automatic send_pair(t_disc_pair p);
        while (!no_idle && $urandom_range(99) < 11) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        pending_results.push_back(resolve_pair(p, restitution_reg));
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {2'b0, p.r2, p.m2, p.v2y, p.v2x, p.p2y, p.p2x,
                            p.r1, p.m1, p.v1y, p.v1x, p.p1y, p.p1x};
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_restitution(logic [E_BITS-1:0] value);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        restitution_reg = value;
        @(posedge i_clk);
    endtask

    function automatic t_disc_pair make_pair(int sx, int sy, int vx1, int vy1, int vx2, int vy2,
                                             int unsigned m1, int unsigned m2,
                                             int unsigned r1, int unsigned r2);
        t_disc_pair p;
        p.p1x = 0; p.p1y = 0; p.v1x = vx1; p.v1y = vy1; p.m1 = m1; p.r1 = 31'(r1);
        p.p2x = sx; p.p2y = sy; p.v2x = vx2; p.v2y = vy2; p.m2 = m2; p.r2 = 31'(r2);
        return p;
    endfunction

    // overlapping or nearly overlapping discs with random content
    function automatic t_disc_pair random_contact_pair();
        t_disc_pair  p;
        int unsigned r1, r2, lim;
        int          base_x, base_y;
        r1 = $urandom_range(1 << 20, 1);
        r2 = $urandom_range(1 << 20, 1);
        lim = r1 + r2;
        base_x = int'($urandom_range(1 << 25)) - (1 << 24);
        base_y = int'($urandom_range(1 << 25)) - (1 << 24);
        p.p1x = base_x;
        p.p1y = base_y;
        p.p2x = base_x + int'($urandom_range(2 * lim)) - int'(lim);
        p.p2y = base_y + int'($urandom_range(2 * lim)) - int'(lim);
        p.r1 = 31'(r1);
        p.r2 = 31'(r2);
        if ($urandom_range(9) == 0) begin
            p.v1x = $urandom(); p.v1y = $urandom(); p.v2x = $urandom(); p.v2y = $urandom();
        end else begin
            p.v1x = int'($urandom_range(1 << 23)) - (1 << 22);
            p.v1y = int'($urandom_range(1 << 23)) - (1 << 22);
            p.v2x = int'($urandom_range(1 << 23)) - (1 << 22);
            p.v2y = int'($urandom_range(1 << 23)) - (1 << 22);
        end
        case ($urandom_range(3))
            0: begin p.m1 = $urandom_range(32'hffffffff, 1); p.m2 = $urandom_range(32'hffffffff, 1); end
            1: begin p.m1 = 1; p.m2 = 32'hffffffff; end
            default: begin
                p.m1 = $urandom_range(1 << 20, 1);
                p.m2 = $urandom_range(1 << 20, 1);
            end
        endcase
        return p;
    endfunction

    function automatic t_disc_pair random_noise_pair();
        t_disc_pair p;
        p.p1x = $urandom(); p.p1y = $urandom(); p.v1x = $urandom(); p.v1y = $urandom();
        p.p2x = $urandom(); p.p2y = $urandom(); p.v2x = $urandom(); p.v2y = $urandom();
        p.m1 = $urandom_range(32'hffffffff, 1);
        p.m2 = $urandom_range(32'hffffffff, 1);
        p.r1 = 31'($urandom());
        p.r2 = 31'($urandom());
        return p;
    endfunction

    always @(posedge i_clk) begin
        i_m_axis_tready <= no_idle || ($urandom_range(99) >= 11);
    end

    always @(posedge i_clk) begin
        t_resolved exp_r;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing expected");
                error_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (o_m_axis_tdata[31:0] !== exp_r.p1x) begin
                    $error("new_first_pos_x exp %h got %h", exp_r.p1x, o_m_axis_tdata[31:0]);
                    error_count++;
                end
                if (o_m_axis_tdata[63:32] !== exp_r.p1y) begin
                    $error("new_first_pos_y exp %h got %h", exp_r.p1y, o_m_axis_tdata[63:32]);
                    error_count++;
                end
                if (o_m_axis_tdata[95:64] !== exp_r.v1x) begin
                    $error("new_first_vel_x exp %h got %h", exp_r.v1x, o_m_axis_tdata[95:64]);
                    error_count++;
                end
                if (o_m_axis_tdata[127:96] !== exp_r.v1y) begin
                    $error("new_first_vel_y exp %h got %h", exp_r.v1y, o_m_axis_tdata[127:96]);
                    error_count++;
                end
                if (o_m_axis_tdata[159:128] !== exp_r.p2x) begin
                    $error("new_second_pos_x exp %h got %h", exp_r.p2x,
                           o_m_axis_tdata[159:128]);
                    error_count++;
                end
                if (o_m_axis_tdata[191:160] !== exp_r.p2y) begin
                    $error("new_second_pos_y exp %h got %h", exp_r.p2y,
                           o_m_axis_tdata[191:160]);
                    error_count++;
                end
                if (o_m_axis_tdata[223:192] !== exp_r.v2x) begin
                    $error("new_second_vel_x exp %h got %h", exp_r.v2x,
                           o_m_axis_tdata[223:192]);
                    error_count++;
                end
                if (o_m_axis_tdata[255:224] !== exp_r.v2y) begin
                    $error("new_second_vel_y exp %h got %h", exp_r.v2y,
                           o_m_axis_tdata[255:224]);
                    error_count++;
                end
                if (o_m_axis_tuser[0] !== exp_r.contact) begin
                    $error("in_contact exp %b got %b", exp_r.contact, o_m_axis_tuser[0]);
                    error_count++;
                end
                if (o_m_axis_tuser[1] !== exp_r.impulse) begin
                    $error("impulse_applied exp %b got %b", exp_r.impulse, o_m_axis_tuser[1]);
                    error_count++;
                end
            end
        end
    end

    task automatic test_special_cases();
        t_disc_pair p;
        // apart, touching exactly, zero radii, coincident
        send_pair(make_pair(3 << 16, 0, 0, 0, 0, 0, 1 << 16, 1 << 16, 1 << 16, 1 << 16));
        send_pair(make_pair(2 << 16, 0, 1 << 16, 0, -(1 << 16), 0, 1 << 16, 1 << 16,
                            1 << 16, 1 << 16));
        send_pair(make_pair(1, 1, 0, 0, 0, 0, 1 << 16, 1 << 16, 0, 0));
        send_pair(make_pair(0, 0, 1 << 16, 0, 0, 0, 1 << 16, 1 << 16, 1 << 16, 1 << 16));
        // coincident, with unit masses
        send_pair(make_pair(0, 0, 5, 0, -5, 0, 1, 1, 1 << 10, 1 << 10));
        // separating and resting
        send_pair(make_pair(1 << 16, 0, -(1 << 16), 0, 1 << 16, 0, 1 << 16, 1 << 16,
                            1 << 16, 1 << 16));
        send_pair(make_pair(0, 1 << 16, 0, 0, 0, 0, 1 << 16, 1 << 16, 1 << 16, 1 << 16));
        // head-on and diagonal approach
        send_pair(make_pair(1 << 16, 0, 1 << 16, 0, -(1 << 16), 0, 1 << 16, 1 << 16,
                            1 << 16, 1 << 16));
        send_pair(make_pair(-(1 << 15), -(1 << 15), -(3 << 16), -(1 << 16), 1 << 16, 1 << 16,
                            1 << 16, 2 << 16, 1 << 16, 1 << 16));
        // mass extremes
        send_pair(make_pair(1 << 16, 1 << 14, 1 << 18, 0, 0, 0, 1, 32'hffffffff,
                            1 << 16, 1 << 16));
        send_pair(make_pair(1 << 16, 1 << 14, 1 << 18, 0, 0, 0, 32'hffffffff, 32'hffffffff,
                            1 << 16, 1 << 16));
        // huge radii, positions at the range ends: saturating push
        p = make_pair(-1, 0, 32'h7fffffff, 0, 32'h80000000, 0, 1, 1,
                      31'h7fffffff, 31'h7fffffff);
        p.p1x = 32'h80000000;
        p.p2x = 32'h80000010;
        send_pair(p);
        p.p1x = 32'h7ffffff0;
        p.p2x = 32'h7fffffff;
        p.p1y = 32'h7fffffff;
        p.p2y = 32'h7fffffff;
        send_pair(p);
        p = make_pair(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                      32'h80000000, 32'h80000000, 32'hffffffff, 1,
                      31'h7fffffff, 31'h7fffffff);
        send_pair(p);
        p.p1x = 32'h80000000;
        p.p1y = 32'h80000000;
        send_pair(p);
        wait_drained();
    endtask

    task automatic test_restitution_extremes();
        logic [E_BITS-1:0] settings[3];
        settings[0] = '0;
        settings[1] = 17'h1ffff;
        settings[2] = E_ONE;
        foreach (settings[i]) begin
            write_restitution(settings[i]);
            send_pair(make_pair(1 << 16, 0, 1 << 16, 0, -(1 << 16), 0, 1 << 16, 1 << 16,
                                1 << 16, 1 << 16));
            send_pair(make_pair(3 << 15, 1 << 15, 5 << 16, 2 << 16, -(7 << 16), 0,
                                3 << 16, 1 << 16, 1 << 16, 1 << 16));
        end
        wait_drained();
    endtask

    task automatic run_random_phase(logic [E_BITS-1:0] e_val, int count, bit quiet);
        write_restitution(e_val);
        no_idle = quiet;
        repeat (count) begin
            if ($urandom_range(9) < 7) send_pair(random_contact_pair());
            else send_pair(random_noise_pair());
        end
        wait_drained();
        no_idle = 1'b0;
    endtask

    task automatic test_random_traffic();
        run_random_phase(E_ONE, 140, 1'b0);
        run_random_phase(17'd0, 140, 1'b1);
        run_random_phase(17'h1ffff, 130, 1'b0);
        run_random_phase(17'($urandom_range(65535)), 140, 1'b0);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_special_cases();
        test_restitution_extremes();
        test_random_traffic();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("disc_pair_collision_resolve_core_tb: clean");
        end else begin
            if (pending_results.size() != 0) $error("results still outstanding at the end");
            $display("disc_pair_collision_resolve_core_tb: errors");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("disc_pair_collision_resolve_core_tb: errors");
        $finish;
    end

endmodule

// File: disc_pair_collision_resolve_core.f
+incdir+hdl
hdl/dpcr_pkg.sv
hdl/dpcr_front.sv
hdl/dpcr_queue.sv
hdl/dpcr_back.sv
hdl/disc_pair_collision_resolve_core.sv
hdl/dpcr_checker.sv
tb/sv/disc_pair_collision_resolve_core_tb.sv
